[src/kvt_pkg.sv]
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared codes, state encoding and controller/datapath interface types for
// the key/value table with sorted listing.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int unsigned OP_BITS     = 2;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned COUNT_BITS  = 5;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_LIST   = 2'd2
  } op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_MISS  = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LK_LOAD,
    S_RK_RD,
    S_RK_CMP,
    S_EM_RD,
    S_EM_LD,
    S_WAIT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic add_load;
    logic lookup_read;
    logic lookup_load;
    logic empty_load;
    logic rank_clear;
    logic rank_read;
    logic rank_step;
    logic emit_read;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               count_zero;
    logic               j_last;
    logic               out_done;
    logic               out_last;
  } sts_t;

endpackage

[src/kvt_ram.sv]
// ----------------------------------------------------------------------------
// kvt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kvt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/kvt_datapath.sv]
// ----------------------------------------------------------------------------
// kvt_datapath
// Key compare lanes, entry RAM, rank registers and the result register.
// ----------------------------------------------------------------------------
module kvt_datapath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kvt_pkg::cmd_t                       cmd_i,
  output kvt_pkg::sts_t                       sts_o,
  input  logic [kvt_pkg::OP_BITS-1:0]         operation_i,
  input  logic signed [KEY_BITS-1:0]          key_i,
  input  logic [VALUE_BITS-1:0]               value_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [kvt_pkg::STATUS_BITS-1:0]     status_o,
  output logic signed [KEY_BITS-1:0]          key_out_o,
  output logic [VALUE_BITS-1:0]               value_out_o,
  output logic [kvt_pkg::COUNT_BITS-1:0]      entry_count_o,
  output logic                                last_o
);
  import kvt_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned ENT_W = KEY_BITS + VALUE_BITS;

  logic [OP_BITS-1:0]         op_q;
  logic signed [KEY_BITS-1:0] key_q;
  logic [VALUE_BITS-1:0]      value_q;
  logic [CNT_W-1:0]           count_q;
  logic signed [KEY_BITS-1:0] key_reg_q [DEPTH];
  logic [IDX_W-1:0]           rank_q [DEPTH];
  logic [IDX_W-1:0]           j_q;
  logic [IDX_W-1:0]           p_q;
  logic                       hit_q;

  logic                       out_valid_q;
  logic [STATUS_BITS-1:0]     status_q;
  logic signed [KEY_BITS-1:0] key_out_q;
  logic [VALUE_BITS-1:0]      value_out_q;
  logic                       last_q;

  logic [DEPTH-1:0]           live;
  logic [DEPTH-1:0]           match;
  logic [DEPTH-1:0]           sel;
  logic [IDX_W-1:0]           hit_idx;
  logic [IDX_W-1:0]           sel_idx;
  logic                       dup;
  logic                       full;
  logic                       add_wr;
  logic [IDX_W-1:0]           wr_idx;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [ENT_W-1:0]           rd_data;
  logic signed [KEY_BITS-1:0] rd_key;
  logic [VALUE_BITS-1:0]      rd_val;
  logic [CNT_W-1:0]           count_m1;
  logic                       emit_last;

  always_comb begin
    hit_idx = '0;
    sel_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      live[i]  = CNT_W'(i) < count_q;
      match[i] = live[i] && (key_reg_q[i] == key_q);
      sel[i]   = live[i] && (rank_q[i] == p_q);
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (sel[i]) begin
        sel_idx = sel_idx | IDX_W'(i);
      end
    end
  end

  assign dup       = |match;
  assign full      = (count_q == CNT_W'(DEPTH));
  assign add_wr    = cmd_i.add_load && !dup && !full;
  assign wr_idx    = count_q[IDX_W-1:0];
  assign count_m1  = count_q - CNT_W'(1);
  assign emit_last = (CNT_W'(p_q) == count_m1);

  assign rd_en = cmd_i.lookup_read || cmd_i.rank_read || cmd_i.emit_read;

  always_comb begin
    rd_addr = sel_idx;
    if (cmd_i.lookup_read) begin
      rd_addr = hit_idx;
    end else if (cmd_i.rank_read) begin
      rd_addr = j_q;
    end
  end

  kvt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (add_wr),
    .wr_addr_i (wr_idx),
    .wr_data_i ({key_q, value_q}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_key = $signed(rd_data[ENT_W-1:VALUE_BITS]);
  assign rd_val = rd_data[VALUE_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q    <= operation_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (cmd_i.lookup_read) begin
      hit_q <= dup;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (add_wr && (wr_idx == IDX_W'(i))) begin
        key_reg_q[i] <= key_q;
      end
      if (cmd_i.rank_clear) begin
        rank_q[i] <= '0;
      end else if (cmd_i.rank_step && live[i] && (key_reg_q[i] > rd_key)) begin
        rank_q[i] <= rank_q[i] + IDX_W'(1);
      end
    end
    if (cmd_i.rank_clear) begin
      j_q <= '0;
      p_q <= '0;
    end else begin
      if (cmd_i.rank_step) begin
        j_q <= j_q + IDX_W'(1);
      end
      if (cmd_i.emit_load) begin
        p_q <= p_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (add_wr) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.add_load || cmd_i.lookup_load || cmd_i.empty_load || cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_load) begin
      status_q    <= dup ? ST_DUP : (full ? ST_FULL : ST_OK);
      key_out_q   <= key_q;
      value_out_q <= '0;
      last_q      <= 1'b1;
    end else if (cmd_i.lookup_load) begin
      status_q    <= hit_q ? ST_OK : ST_MISS;
      key_out_q   <= key_q;
      value_out_q <= hit_q ? rd_val : '0;
      last_q      <= 1'b1;
    end else if (cmd_i.empty_load) begin
      status_q    <= ST_EMPTY;
      key_out_q   <= '0;
      value_out_q <= '0;
      last_q      <= 1'b1;
    end else if (cmd_i.emit_load) begin
      status_q    <= ST_OK;
      key_out_q   <= rd_key;
      value_out_q <= rd_val;
      last_q      <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign key_out_o     = key_out_q;
  assign value_out_o   = value_out_q;
  assign entry_count_o = COUNT_BITS'(count_q);
  assign last_o        = last_q;

  assign sts_o.op         = op_q;
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.j_last     = (CNT_W'(j_q) == count_m1);
  assign sts_o.out_done   = out_valid_q && out_ready_i;
  assign sts_o.out_last   = last_q;

endmodule

[src/kvt_ctrl.sv]
// ----------------------------------------------------------------------------
// kvt_ctrl
// Operation sequencer: decode, rank pass, ordered emit and result handoff.
// ----------------------------------------------------------------------------
module kvt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kvt_pkg::sts_t sts_i,
  output kvt_pkg::cmd_t cmd_o
);
  import kvt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_ADD: begin
            cmd_o.add_load = 1'b1;
            state_d        = S_WAIT;
          end
          OP_LOOKUP: begin
            cmd_o.lookup_read = 1'b1;
            state_d           = S_LK_LOAD;
          end
          OP_LIST: begin
            if (sts_i.count_zero) begin
              cmd_o.empty_load = 1'b1;
              state_d          = S_WAIT;
            end else begin
              cmd_o.rank_clear = 1'b1;
              state_d          = S_RK_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_LK_LOAD: begin
        cmd_o.lookup_load = 1'b1;
        state_d           = S_WAIT;
      end
      S_RK_RD: begin
        cmd_o.rank_read = 1'b1;
        state_d         = S_RK_CMP;
      end
      S_RK_CMP: begin
        cmd_o.rank_step = 1'b1;
        state_d         = sts_i.j_last ? S_EM_RD : S_RK_RD;
      end
      S_EM_RD: begin
        cmd_o.emit_read = 1'b1;
        state_d         = S_EM_LD;
      end
      S_EM_LD: begin
        cmd_o.emit_load = 1'b1;
        state_d         = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.out_done) begin
          state_d = sts_i.out_last ? S_IDLE : S_EM_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[src/key_value_table_sorted_dump_unit.sv]
// ----------------------------------------------------------------------------
// key_value_table_sorted_dump_unit
// Table of up to DEPTH unique signed keys with values: add, lookup and a
// listing in ascending signed key order.
//
// Input channel (in_valid_i/in_ready_o) takes one request at a time; the
// output channel (out_valid_o/out_ready_i) returns its results from a result
// register, last_o marking the final one. Operation code 3 yields no result.
// A listing first runs a rank pass (one entry RAM read and one compare across
// all key lanes per entry), then emits the results one at a time, each only
// after the previous one is taken (select by rank, RAM read, load). The
// sequencer is ready for the next request in the cycle after the last result
// is taken. A stalled receiver holds the result register and the sequencer;
// nothing is dropped. Reset empties the table at once; stored keys and
// values are not cleared.
// ----------------------------------------------------------------------------
module key_value_table_sorted_dump_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [kvt_pkg::OP_BITS-1:0]     operation_i,
  input  logic signed [KEY_BITS-1:0]      key_i,
  input  logic [VALUE_BITS-1:0]           value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [kvt_pkg::STATUS_BITS-1:0] status_o,
  output logic signed [KEY_BITS-1:0]      key_out_o,
  output logic [VALUE_BITS-1:0]           value_out_o,
  output logic [kvt_pkg::COUNT_BITS-1:0]  entry_count_o,
  output logic                            last_o
);
  import kvt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kvt_datapath #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .key_out_o     (key_out_o),
    .value_out_o   (value_out_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while a result is pending");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> in_ready_o)
    else $error("not ready after final result");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(entry_count_o))
    else $error("entry count moved under stall");

  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> last_o && (entry_count_o == '0))
    else $error("malformed empty result");

endmodule

[test/kvt_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kvt_checker
// Watches the request and result channels of the key/value table, keeps its
// own copy of the table, predicts the results of every accepted request and
// compares each accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module kvt_checker #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [kvt_pkg::OP_BITS-1:0]     operation_i,
  input  logic signed [KEY_BITS-1:0]      key_i,
  input  logic [VALUE_BITS-1:0]           value_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [kvt_pkg::STATUS_BITS-1:0] status_i,
  input  logic signed [KEY_BITS-1:0]      key_out_i,
  input  logic [VALUE_BITS-1:0]           value_out_i,
  input  logic [kvt_pkg::COUNT_BITS-1:0]  entry_count_i,
  input  logic                            last_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     outstanding_o
);
  import kvt_pkg::*;

  typedef struct {
    status_e                    status;
    logic signed [KEY_BITS-1:0] key;
    logic [VALUE_BITS-1:0]      value;
    logic [COUNT_BITS-1:0]      count;
    logic                       last;
  } table_result_t;

  logic signed [KEY_BITS-1:0] key_tab [DEPTH];
  logic [VALUE_BITS-1:0]      value_tab [DEPTH];
  int                         fill = 0;
  table_result_t              expected_q [$];

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
  end

  function automatic int find_entry(logic signed [KEY_BITS-1:0] k);
    for (int i = 0; i < fill; i++) begin
      if (key_tab[i] == k) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void push_result(status_e st, logic signed [KEY_BITS-1:0] k,
                                      logic [VALUE_BITS-1:0] v, logic last);
    table_result_t r;
    r.status = st;
    r.key    = k;
    r.value  = v;
    r.count  = fill[COUNT_BITS-1:0];
    r.last   = last;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_request(logic [OP_BITS-1:0] op,
                                          logic signed [KEY_BITS-1:0] k,
                                          logic [VALUE_BITS-1:0] v);
    int pos;
    int j;
    int order [DEPTH];
    case (op)
      OP_ADD: begin
        if (find_entry(k) >= 0) begin
          push_result(ST_DUP, k, '0, 1'b1);
        end else if (fill >= DEPTH) begin
          push_result(ST_FULL, k, '0, 1'b1);
        end else begin
          key_tab[fill]   = k;
          value_tab[fill] = v;
          fill++;
          push_result(ST_OK, k, '0, 1'b1);
        end
      end
      OP_LOOKUP: begin
        pos = find_entry(k);
        if (pos < 0) begin
          push_result(ST_MISS, k, '0, 1'b1);
        end else begin
          push_result(ST_OK, k, value_tab[pos], 1'b1);
        end
      end
      OP_LIST: begin
        if (fill == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          // insertion sort of entry indexes by signed key
          for (int i = 0; i < fill; i++) begin
            j = i;
            while (j > 0 && key_tab[i] < key_tab[order[j-1]]) begin
              order[j] = order[j-1];
              j--;
            end
            order[j] = i;
          end
          for (int i = 0; i < fill; i++) begin
            push_result(ST_OK, key_tab[order[i]], value_tab[order[i]], i == fill - 1);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    table_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d key %h value %h",
                   $time, status_i, key_out_i, value_out_i);
          fail_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          compare_field("status", 64'(exp_r.status), 64'(status_i));
          compare_field("key_out", 64'(exp_r.key), 64'(key_out_i));
          compare_field("value_out", 64'(exp_r.value), 64'(value_out_i));
          compare_field("entry_count", 64'(exp_r.count), 64'(entry_count_i));
          compare_field("last", 64'(exp_r.last), 64'(last_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_request(operation_i, key_i, value_i);
      end
      outstanding_o = expected_q.size();
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Request generator for the key/value table: directed requests for empty,
// duplicate, miss, full and extreme-key cases, then random requests under
// several sender and receiver idling phases. Checking is done by kvt_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import kvt_pkg::*;

  localparam int unsigned DEPTH            = 16;
  localparam int unsigned KEY_BITS         = 32;
  localparam int unsigned VALUE_BITS       = 32;
  localparam int unsigned RANDOM_PER_PHASE = 30;
  localparam int unsigned DRAIN_CYCLES     = 64;
  localparam int unsigned CYCLE_LIMIT      = 600000;

  localparam logic [OP_BITS-1:0]         OP_UNUSED = 2'd3;
  localparam logic signed [KEY_BITS-1:0] KEY_MIN   = {1'b1, {(KEY_BITS-1){1'b0}}};
  localparam logic signed [KEY_BITS-1:0] KEY_MAX   = ~KEY_MIN;

  localparam int SEND_IDLE_PCT [4]  = '{0, 87, 0, 21};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 87, 21};

  logic                       clk;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  logic [OP_BITS-1:0]         operation   = '0;
  logic signed [KEY_BITS-1:0] key         = '0;
  logic [VALUE_BITS-1:0]      value       = '0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  logic [STATUS_BITS-1:0]     status;
  logic signed [KEY_BITS-1:0] key_out;
  logic [VALUE_BITS-1:0]      value_out;
  logic [COUNT_BITS-1:0]      entry_count;
  logic                       last;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned fail_count;
  int unsigned outstanding;

  logic signed [KEY_BITS-1:0] added_keys [$];

  key_value_table_sorted_dump_unit #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .operation_i   (operation),
    .key_i         (key),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .key_out_o     (key_out),
    .value_out_o   (value_out),
    .entry_count_o (entry_count),
    .last_o        (last)
  );

  kvt_checker #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .operation_i   (operation),
    .key_i         (key),
    .value_i       (value),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .key_out_i     (key_out),
    .value_out_i   (value_out),
    .entry_count_i (entry_count),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [KEY_BITS-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (added_keys.size() > 0 && r < 65) begin
      return added_keys[$urandom_range(added_keys.size() - 1)];
    end else if (r < 72) begin
      return KEY_MIN;
    end else if (r < 79) begin
      return KEY_MAX;
    end
    return $urandom;
  endfunction

  // hold the request until accepted; in_ready is sampled away from the edge
  task automatic send_request(logic [OP_BITS-1:0] op, logic signed [KEY_BITS-1:0] k,
                              logic [VALUE_BITS-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    key       <= k;
    value     <= v;
    if (op == OP_ADD) begin
      added_keys.push_back(k);
    end
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  initial begin
    int pick;
    int issued;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_LIST, $urandom, $urandom);
    send_request(OP_LOOKUP, KEY_MIN, $urandom);
    send_request(OP_UNUSED, $urandom, $urandom);
    send_request(OP_ADD, KEY_MIN, '0);
    send_request(OP_ADD, KEY_MAX, '1);
    send_request(OP_ADD, '0, $urandom);
    send_request(OP_ADD, '1, $urandom);
    send_request(OP_ADD, KEY_MAX, $urandom);
    send_request(OP_LOOKUP, KEY_MIN, $urandom);
    send_request(OP_LOOKUP, KEY_MAX, $urandom);
    send_request(OP_LOOKUP, 32'sd12345, $urandom);
    send_request(OP_LIST, $urandom, $urandom);
    for (int i = 4; i < DEPTH; i++) begin
      send_request(OP_ADD, $urandom, $urandom);
    end
    send_request(OP_ADD, '0, $urandom);
    send_request(OP_ADD, 32'sd777, $urandom);
    send_request(OP_LIST, $urandom, $urandom);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = SEND_IDLE_PCT[p];
      recv_stall_pct = RECV_STALL_PCT[p];
      issued = 0;
      while (issued < RANDOM_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          send_request(OP_ADD, pick_key(), $urandom);
          issued++;
        end else if (pick < 70) begin
          send_request(OP_LOOKUP, pick_key(), $urandom);
          issued++;
        end else if (pick < 85) begin
          send_request(OP_LIST, $urandom, $urandom);
          issued++;
        end else if (pick < 90) begin
          send_request(OP_UNUSED, $urandom, $urandom);
        end else begin
          send_request(OP_LOOKUP, $urandom, $urandom);
          issued++;
        end
      end
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
